// ===== rtl/skrt_pkg.sv =====
package skrt_pkg;

  // Table geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned OP_W    = 3;
  localparam int unsigned KEY_W   = 40;
  localparam int unsigned SCORE_W = 14;
  localparam int unsigned TAG_W   = 32;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT     = 3'd0,
    OP_REM_SMALL  = 3'd1,
    OP_REM_LARGE  = 3'd2,
    OP_REM_KEY    = 3'd3,
    OP_LIST       = 3'd4
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // What the cells do on this cycle
  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_LIST = 2'd2
  } state_e;

  // Input item
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [KEY_W-1:0]   key;
    logic               gender;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   name_tag;
  } in_t;

  // Result item
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [KEY_W-1:0]   out_key;
    logic               out_gender;
    logic [SCORE_W-1:0] out_score;
    logic [TAG_W-1:0]   out_name_tag;
    logic               last;
  } out_t;

  // One stored record
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic               gender;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   name_tag;
  } rec_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    act_e             act;
    logic             by_key;
    logic [IDX_W-1:0] sel_idx;
    logic [CNT_W-1:0] count;
    logic [KEY_W-1:0] key;
    rec_t             new_rec;
  } cell_ctrl_t;

  // Link passed from a cell to its right neighbor
  typedef struct packed {
    logic lt;        // this cell holds a key below the search key
    logic hit;       // a key match at or left of this cell
    logic sel_seen;  // the selected cell is at or left of this cell
    rec_t rec;       // this cell's record
    rec_t acc;       // selected record, gathered along the chain
  } link_t;

endpackage

// ===== rtl/skrt_cell.sv =====
module skrt_cell (
  input  logic                          clk_i,
  input  logic [skrt_pkg::IDX_W-1:0]    idx_i,
  input  skrt_pkg::cell_ctrl_t          ctrl_i,
  input  skrt_pkg::link_t               link_i,
  input  skrt_pkg::rec_t                right_rec_i,
  output skrt_pkg::link_t               link_o
);
  import skrt_pkg::*;

  rec_t rec_q, rec_d;
  logic occ, lt, match, first_hit, sel, sel_seen;

  // Local compares against the broadcast key
  assign occ       = CNT_W'(idx_i) < ctrl_i.count;
  assign lt        = occ && (rec_q.key < ctrl_i.key);
  assign match     = occ && (rec_q.key == ctrl_i.key);
  assign first_hit = match && !link_i.hit;
  assign sel       = ctrl_i.by_key ? first_hit : (idx_i == ctrl_i.sel_idx);
  assign sel_seen  = link_i.sel_seen | sel;

  // Hand on to the right neighbor
  always_comb begin
    link_o.lt       = lt;
    link_o.hit      = link_i.hit | match;
    link_o.sel_seen = sel_seen;
    link_o.rec      = rec_q;
    link_o.acc      = link_i.acc | (sel ? rec_q : '0);
  end

  // Insert shifts right past the insertion point, remove shifts left into the gap
  always_comb begin
    rec_d = rec_q;
    case (ctrl_i.act)
      ACT_INSERT: begin
        if (!lt) begin
          rec_d = link_i.lt ? ctrl_i.new_rec : link_i.rec;
        end
      end
      ACT_REMOVE: begin
        if (sel_seen) begin
          rec_d = right_rec_i;
        end
      end
      default: rec_d = rec_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule

// ===== rtl/skrt_ctrl.sv =====
module skrt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  skrt_pkg::in_t          in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output skrt_pkg::out_t         out_data_o,
  output skrt_pkg::cell_ctrl_t   cell_ctrl_o,
  input  skrt_pkg::link_t        chain_i
);
  import skrt_pkg::*;

  state_e           state_q, state_d;
  in_t              item_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] lidx_q, lidx_d;
  out_t             out_q, out_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free, in_xfer, is_full, is_empty, list_last;
  op_e              op;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign op          = op_e'(item_q.operation);
  assign is_full     = (count_q == CNT_W'(DEPTH));
  assign is_empty    = (count_q == '0);
  assign list_last   = (CNT_W'(lidx_q) == count_q - CNT_W'(1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op == OP_LIST && !is_empty) begin
          state_d = S_LIST;
        end else if (out_free) begin
          state_d = S_IDLE;
        end else if (op != OP_INSERT && op != OP_REM_SMALL && op != OP_REM_LARGE &&
                     op != OP_REM_KEY && op != OP_LIST) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Cell commands, count update and result register
  always_comb begin
    cell_ctrl_o.act      = ACT_HOLD;
    cell_ctrl_o.by_key   = 1'b0;
    cell_ctrl_o.sel_idx  = '0;
    cell_ctrl_o.count    = count_q;
    cell_ctrl_o.key      = item_q.key;
    cell_ctrl_o.new_rec  = '{key: item_q.key, gender: item_q.gender,
                             score: item_q.score, name_tag: item_q.name_tag};
    count_d     = count_q;
    lidx_d      = lidx_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_EXEC: begin
        lidx_d = '0;
        if (out_free) begin
          out_d      = '0;
          out_d.last = 1'b1;
          unique case (op) inside
            OP_INSERT: begin
              out_valid_d = 1'b1;
              if (is_full) begin
                out_d.status = ST_FULL;
              end else begin
                out_d.status    = ST_OK;
                cell_ctrl_o.act = ACT_INSERT;
                count_d         = count_q + CNT_W'(1);
              end
            end
            OP_REM_SMALL, OP_REM_LARGE, OP_REM_KEY: begin
              out_valid_d         = 1'b1;
              cell_ctrl_o.by_key  = (op == OP_REM_KEY);
              cell_ctrl_o.sel_idx = (op == OP_REM_LARGE) ?
                                    IDX_W'(count_q - CNT_W'(1)) : '0;
              if (is_empty) begin
                out_d.status = ST_EMPTY;
              end else if (op == OP_REM_KEY && !chain_i.hit) begin
                out_d.status = ST_NOT_FOUND;
              end else begin
                out_d.status       = ST_OK;
                out_d.out_key      = chain_i.acc.key;
                out_d.out_gender   = chain_i.acc.gender;
                out_d.out_score    = chain_i.acc.score;
                out_d.out_name_tag = chain_i.acc.name_tag;
                cell_ctrl_o.act    = ACT_REMOVE;
                count_d            = count_q - CNT_W'(1);
              end
            end
            OP_LIST: begin
              // records stream from the list state
              if (is_empty) begin
                out_valid_d  = 1'b1;
                out_d.status = ST_EMPTY;
              end
            end
            default: out_d = out_q;
          endcase
        end
      end
      S_LIST: begin
        cell_ctrl_o.sel_idx = lidx_q;
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.status       = ST_OK;
          out_d.out_key      = chain_i.acc.key;
          out_d.out_gender   = chain_i.acc.gender;
          out_d.out_score    = chain_i.acc.score;
          out_d.out_name_tag = chain_i.acc.name_tag;
          out_d.last         = list_last;
          lidx_d             = lidx_q + IDX_W'(1);
        end
      end
      default: begin
        lidx_d = lidx_q;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      lidx_q      <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      lidx_q      <= lidx_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    out_q <= out_d;
  end

endmodule

// ===== rtl/sorted_key_record_table_unit.sv =====
// A single-result operation registers the item, then its result in the output register once that register is free.
// The unit takes a new item only once it has finished the last one; a list holds the input while it
// streams its records, one record per cycle, and stalls while the output register is held.
// The cell row compares the key, shifts and picks the output record in the same cycle.
// Reset clears the record count, the state machine and the output valid;
// record contents are not reset.
module sorted_key_record_table_unit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  skrt_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output skrt_pkg::out_t  out_data_o
);
  import skrt_pkg::*;

  cell_ctrl_t cell_ctrl;
  link_t      link [DEPTH+1];

  // Head of the chain: everything inserts after it, nothing selected yet
  always_comb begin
    link[0]          = '0;
    link[0].lt       = 1'b1;
  end

  skrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cell_ctrl_o (cell_ctrl),
    .chain_i     (link[DEPTH])
  );

  // Row of record cells, smallest key at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t right_rec;
    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = link[i+1].rec;
    end else begin : g_body
      assign right_rec = link[i+2].rec;
    end
    skrt_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (IDX_W'(i)),
      .ctrl_i      (cell_ctrl),
      .link_i      (link[i]),
      .right_rec_i (right_rec),
      .link_o      (link[i+1])
    );
  end

endmodule

// ===== rtl/skrt_checker.sv =====
module skrt_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_o,
  input  logic            out_valid_o,
  input  logic            out_ready_i,
  input  skrt_pkg::out_t  out_data_o
);
  import skrt_pkg::*;

  // A held result does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // One item at a time: no transfer on the cycle after a transfer
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in work");

  // An error status always closes its item
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |-> out_data_o.last)
    else $error("error status without last");

  // An error status carries no record
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.out_key == '0) && (out_data_o.out_score == '0) &&
      (out_data_o.out_name_tag == '0) && !out_data_o.out_gender)
    else $error("error status with record fields");

endmodule

bind sorted_key_record_table_unit skrt_checker u_skrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
